/* hdl/rswm_pkg.sv */
// ----------------------------------------------------------------------------
// rswm_pkg
// Shared types and constants of the row sliding-window max/min filter.
// ----------------------------------------------------------------------------
`default_nettype none

package rswm_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int RAD_BITS       = 5;
  localparam int FILL_BITS      = 7;
  localparam int MAX_RADIUS_DEF = 31;
  localparam int IN_Q_DEPTH     = 4;
  localparam int PADDR_BITS     = 3;
  localparam int PDATA_BITS     = 32;

  // register select, taken from paddr[2]
  localparam logic REG_RADIUS = 1'b0;
  localparam logic REG_MODE   = 1'b1;

  localparam logic [RAD_BITS-1:0] RADIUS_RST = '0;
  localparam logic                MODE_RST   = 1'b1;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] pixel_value;
    logic                   row_end;
  } in_item_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] filtered_value;
    logic                   row_done;
  } out_item_t;

  typedef struct packed {
    in_item_t               pix;
    logic [FILL_BITS-1:0]   fill;
    logic [RAD_BITS-1:0]    rad;
    logic                   dilate;
  } q_item_t;

  typedef struct packed {
    logic                   vld;
    logic [FILL_BITS-1:0]   span;
    logic [FILL_BITS-1:0]   fill;
    logic                   dilate;
    logic                   row_done;
  } pass_t;

endpackage

`default_nettype wire

/* hdl/rswm_fifo.sv */
// ----------------------------------------------------------------------------
// rswm_fifo
// Small synchronous FIFO in flops, power-of-two depth.
// ----------------------------------------------------------------------------
`default_nettype none

module rswm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] dout,
  output logic                  full,
  output logic                  empty
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW:0]      wr_ptr_r, wr_ptr_nxt;
  logic [AW:0]      rd_ptr_r, rd_ptr_nxt;
  logic             do_push, do_pop;

  assign full    = (wr_ptr_r[AW] != rd_ptr_r[AW]) && (wr_ptr_r[AW-1:0] == rd_ptr_r[AW-1:0]);
  assign empty   = (wr_ptr_r == rd_ptr_r);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r[AW-1:0]];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + (AW+1)'(do_push);
    rd_ptr_nxt = rd_ptr_r + (AW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r[AW-1:0]] <= din;
    end
  end

endmodule

`default_nettype wire

/* hdl/rswm_front.sv */
// ----------------------------------------------------------------------------
// rswm_front
// Config registers, row pixel count and tagging of each accepted pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module rswm_front #(
  parameter int MAX_RADIUS = rswm_pkg::MAX_RADIUS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [rswm_pkg::PADDR_BITS-1:0] paddr,
  input  wire logic [rswm_pkg::PDATA_BITS-1:0] pwdata,
  output logic      [rswm_pkg::PDATA_BITS-1:0] prdata,
  output logic                                 pready,
  input  wire logic                            push,
  input  wire rswm_pkg::in_item_t              in_item,
  input  wire logic                            q_full,
  output logic                                 q_push,
  output rswm_pkg::q_item_t                    q_item
);

  localparam int FW = rswm_pkg::FILL_BITS;
  localparam int RW = rswm_pkg::RAD_BITS;

  logic [RW-1:0] radius_r, radius_nxt;
  logic          dilate_r, dilate_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [FW-1:0] fill_inc;
  logic [RW-1:0] eff_rad;
  logic          wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign q_push = push && !q_full;

  always_comb begin
    unique case (paddr[rswm_pkg::PADDR_BITS-1])
      rswm_pkg::REG_RADIUS: prdata = rswm_pkg::PDATA_BITS'(radius_r);
      rswm_pkg::REG_MODE:   prdata = rswm_pkg::PDATA_BITS'(dilate_r);
      default:              prdata = '0;
    endcase
  end

  always_comb begin
    radius_nxt = radius_r;
    dilate_nxt = dilate_r;
    if (wr_en) begin
      unique case (paddr[rswm_pkg::PADDR_BITS-1])
        rswm_pkg::REG_RADIUS: radius_nxt = pwdata[RW-1:0];
        rswm_pkg::REG_MODE:   dilate_nxt = pwdata[0];
        default: ;
      endcase
    end
  end

  // saturating count of pixels so far in the row
  always_comb begin
    eff_rad  = (int'(radius_r) > MAX_RADIUS) ? RW'(MAX_RADIUS) : radius_r;
    fill_inc = (fill_r == {FW{1'b1}}) ? fill_r : fill_r + 1'b1;
    fill_nxt = fill_r;
    if (q_push) begin
      fill_nxt = in_item.row_end ? '0 : fill_inc;
    end
    q_item.pix    = in_item;
    q_item.fill   = fill_inc;
    q_item.rad    = eff_rad;
    q_item.dilate = dilate_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= rswm_pkg::RADIUS_RST;
      dilate_r <= rswm_pkg::MODE_RST;
      fill_r   <= '0;
    end else begin
      radius_r <= radius_nxt;
      dilate_r <= dilate_nxt;
      fill_r   <= fill_nxt;
    end
  end

endmodule

`default_nettype wire

/* hdl/rswm_tree.sv */
// ----------------------------------------------------------------------------
// rswm_tree
// Pipelined max/min tree over the history taps, one register per level.
// ----------------------------------------------------------------------------
`default_nettype none

module rswm_tree #(
  parameter int MAX_RADIUS = rswm_pkg::MAX_RADIUS_DEF
) (
  input  wire logic                                                    clk,
  input  wire logic                                                    rst_n,
  input  wire rswm_pkg::pass_t                                         pass,
  input  wire logic [2*MAX_RADIUS:0][rswm_pkg::SAMPLE_BITS-1:0]        hist,
  output logic                                                         res_vld,
  output rswm_pkg::out_item_t                                          res
);

  localparam int SW     = rswm_pkg::SAMPLE_BITS;
  localparam int FW     = rswm_pkg::FILL_BITS;
  localparam int WIN    = 2*MAX_RADIUS+1;
  localparam int LVLS   = $clog2(WIN);
  localparam int LEAVES = 1 << LVLS;

  logic [SW-1:0] leaf [LEAVES];
  logic [SW-1:0] node_r [1:2*LEAVES-1];
  logic          vld_r  [0:LVLS];
  logic          dil_r  [0:LVLS];
  logic          done_r [0:LVLS];
  logic [SW-1:0] ident;

  function automatic logic [SW-1:0] pick(input logic [SW-1:0] a, input logic [SW-1:0] b,
                                         input logic mx);
    if (mx) begin
      return (a > b) ? a : b;
    end
    return (a < b) ? a : b;
  endfunction

  assign ident = pass.dilate ? '0 : '1;

  for (genvar k = 0; k < LEAVES; k++) begin : g_leaf
    if (k == 0) begin : g_newest
      assign leaf[k] = hist[k];
    end else if (k < WIN) begin : g_tap
      assign leaf[k] = ((FW'(k) <= pass.span) && (FW'(k) < pass.fill)) ? hist[k] : ident;
    end else begin : g_pad
      assign leaf[k] = ident;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < LEAVES; k++) begin
      node_r[LEAVES+k] <= leaf[k];
    end
    for (int d = 0; d < LVLS; d++) begin
      for (int i = (1 << d); i < (2 << d); i++) begin
        node_r[i] <= pick(node_r[2*i], node_r[2*i+1], dil_r[LVLS-d-1]);
      end
    end
    dil_r[0]  <= pass.dilate;
    done_r[0] <= pass.row_done;
    for (int s = 1; s <= LVLS; s++) begin
      dil_r[s]  <= dil_r[s-1];
      done_r[s] <= done_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= LVLS; s++) begin
        vld_r[s] <= 1'b0;
      end
    end else begin
      vld_r[0] <= pass.vld;
      for (int s = 1; s <= LVLS; s++) begin
        vld_r[s] <= vld_r[s-1];
      end
    end
  end

  assign res_vld            = vld_r[LVLS];
  assign res.filtered_value = node_r[1];
  assign res.row_done       = done_r[LVLS];

endmodule

`default_nettype wire

/* hdl/rswm_back.sv */
// ----------------------------------------------------------------------------
// rswm_back
// History shift line and pass sequencer: at most one pass per pixel, a burst of
// passes with shrinking windows at row end. Credits bound the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rswm_back #(
  parameter int MAX_RADIUS = rswm_pkg::MAX_RADIUS_DEF,
  parameter int OUT_DEPTH  = 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                q_empty,
  input  wire rswm_pkg::q_item_t   q_item,
  output logic                     q_pop,
  input  wire logic                ret,
  output logic                     res_vld,
  output rswm_pkg::out_item_t      res
);

  localparam int SW  = rswm_pkg::SAMPLE_BITS;
  localparam int FW  = rswm_pkg::FILL_BITS;
  localparam int RW  = rswm_pkg::RAD_BITS;
  localparam int WIN = 2*MAX_RADIUS+1;
  localparam int CW  = $clog2(OUT_DEPTH+1);

  logic [WIN-1:0][SW-1:0] hist_r, hist_nxt;
  logic                   flush_r, flush_nxt;
  logic [RW-1:0]          j_r, j_nxt;
  logic [RW-1:0]          rad_r, rad_nxt;
  logic [FW-1:0]          fill_r, fill_nxt;
  logic                   dil_r, dil_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic                   can_issue;
  logic                   need;
  logic                   last;
  logic [FW-1:0]          r_ext;
  logic [FW-1:0]          fm1;
  logic [RW-1:0]          jstart;
  rswm_pkg::pass_t        pass;

  always_comb begin
    can_issue = (cnt_r < CW'(OUT_DEPTH));
    last      = q_item.pix.row_end;
    r_ext     = FW'(q_item.rad);
    fm1       = q_item.fill - 1'b1;
    need      = last || (r_ext < q_item.fill);
    jstart    = (r_ext < q_item.fill) ? q_item.rad : RW'(fm1);

    q_pop     = 1'b0;
    hist_nxt  = hist_r;
    flush_nxt = flush_r;
    j_nxt     = j_r;
    rad_nxt   = rad_r;
    fill_nxt  = fill_r;
    dil_nxt   = dil_r;
    pass      = '0;

    if (flush_r) begin
      if (can_issue) begin
        pass.vld      = 1'b1;
        pass.span     = FW'(j_r) + FW'(rad_r);
        pass.fill     = fill_r;
        pass.dilate   = dil_r;
        pass.row_done = (j_r == '0);
        flush_nxt     = (j_r != '0);
        j_nxt         = j_r - 1'b1;
      end
    end else if (!q_empty && (!need || can_issue)) begin
      q_pop    = 1'b1;
      hist_nxt = {hist_r[WIN-2:0], q_item.pix.pixel_value};
      if (need) begin
        pass.vld    = 1'b1;
        pass.fill   = q_item.fill;
        pass.dilate = q_item.dilate;
        if (last) begin
          pass.span     = FW'(jstart) + r_ext;
          pass.row_done = (jstart == '0);
          flush_nxt     = (jstart != '0);
          j_nxt         = jstart - 1'b1;
          rad_nxt       = q_item.rad;
          fill_nxt      = q_item.fill;
          dil_nxt       = q_item.dilate;
        end else begin
          pass.span     = r_ext << 1;
          pass.row_done = 1'b0;
        end
      end
    end

    cnt_nxt = cnt_r + CW'(pass.vld) - CW'(ret);
  end

  always_ff @(posedge clk) begin
    hist_r <= hist_nxt;
    j_r    <= j_nxt;
    rad_r  <= rad_nxt;
    fill_r <= fill_nxt;
    dil_r  <= dil_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flush_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      flush_r <= flush_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  rswm_tree #(
    .MAX_RADIUS(MAX_RADIUS)
  ) u_tree (
    .clk     (clk),
    .rst_n   (rst_n),
    .pass    (pass),
    .hist    (hist_nxt),
    .res_vld (res_vld),
    .res     (res)
  );

endmodule

`default_nettype wire

/* hdl/row_sliding_window_max_min.sv */
// Path: input queue, pass sequencer, pipelined max/min tree, then output queue.
// Throughput: one pixel per cycle unless a row-end burst runs or result credits are out;
// a row end with radius r issues up to r+1 results, one at a time via the tree's pass port.
// Reset: synchronous, active low; clears config, row count and queues.
// Sample history is not cleared; only taps written in the current row are used.
// ----------------------------------------------------------------------------
// row_sliding_window_max_min
// Flat 1-D grayscale dilate/erode along an image row with APB config.
// ----------------------------------------------------------------------------
`default_nettype none

module row_sliding_window_max_min #(
  parameter int MAX_RADIUS = rswm_pkg::MAX_RADIUS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            push,
  output logic                                 full,
  input  wire rswm_pkg::in_item_t              in_item,
  output logic                                 empty,
  input  wire logic                            pop,
  output rswm_pkg::out_item_t                  out_item,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [rswm_pkg::PADDR_BITS-1:0] paddr,
  input  wire logic [rswm_pkg::PDATA_BITS-1:0] pwdata,
  output logic      [rswm_pkg::PDATA_BITS-1:0] prdata,
  output logic                                 pready
);

  // credits cover the full issue-to-pop round trip
  localparam int LVLS      = $clog2(2*MAX_RADIUS+1);
  localparam int OUT_DEPTH = 1 << $clog2(LVLS+3);

  logic                q_push, q_pop, q_empty;
  rswm_pkg::q_item_t   q_wr, q_rd;
  logic                res_vld;
  rswm_pkg::out_item_t res;
  logic                ret;

  assign ret = pop && !empty;

  rswm_front #(
    .MAX_RADIUS(MAX_RADIUS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .push    (push),
    .in_item (in_item),
    .q_full  (full),
    .q_push  (q_push),
    .q_item  (q_wr)
  );

  rswm_fifo #(
    .WIDTH($bits(rswm_pkg::q_item_t)),
    .DEPTH(rswm_pkg::IN_Q_DEPTH)
  ) u_in_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_wr),
    .pop   (q_pop),
    .dout  (q_rd),
    .full  (full),
    .empty (q_empty)
  );

  rswm_back #(
    .MAX_RADIUS(MAX_RADIUS),
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_item  (q_rd),
    .q_pop   (q_pop),
    .ret     (ret),
    .res_vld (res_vld),
    .res     (res)
  );

  rswm_fifo #(
    .WIDTH($bits(rswm_pkg::out_item_t)),
    .DEPTH(OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_vld),
    .din   (res),
    .pop   (pop),
    .dout  (out_item),
    .full  (),
    .empty (empty)
  );

endmodule

`default_nettype wire

/* dv/row_sliding_window_max_min_test.sv */
// ----------------------------------------------------------------------------
// row_sliding_window_max_min_test
// Self-checking bench for the row dilate/erode filter. Pixel words go in
// through the push/full side and are fed to a cycle-free predictor of the
// window max/min, which queues the expected output words. A checker compares
// each popped word with the oldest expectation. Directed rows cover reset
// defaults, one-pixel rows, rows shorter than the window and a radius change
// inside a row. Random rows then run under several idle/stall mixes and a
// long receiver hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
`default_nettype none

module row_sliding_window_max_min_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HIST_DEPTH    = 2 * rswm_pkg::MAX_RADIUS_DEF + 2;
  localparam int FILL_SAT      = 127;
  localparam int SETTLE_CYCLES = 32;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int MAX_REPORTS   = 10;
  localparam int HOLD_CYCLES   = 400;

  localparam logic [rswm_pkg::PADDR_BITS-1:0] ADDR_RADIUS = {rswm_pkg::REG_RADIUS, 2'b00};
  localparam logic [rswm_pkg::PADDR_BITS-1:0] ADDR_MODE   = {rswm_pkg::REG_MODE, 2'b00};

  logic                            clk     = 1'b0;
  logic                            rst_n   = 1'b0;
  logic                            push    = 1'b0;
  logic                            pop     = 1'b0;
  logic                            psel    = 1'b0;
  logic                            penable = 1'b0;
  logic                            pwrite  = 1'b0;
  logic [rswm_pkg::PADDR_BITS-1:0] paddr   = '0;
  logic [rswm_pkg::PDATA_BITS-1:0] pwdata  = '0;
  rswm_pkg::in_item_t              in_item = '0;
  logic                            full;
  logic                            empty;
  logic                            pready;
  rswm_pkg::out_item_t             out_item;
  logic [rswm_pkg::PDATA_BITS-1:0] prdata;

  row_sliding_window_max_min DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_item (in_item),
    .empty   (empty),
    .pop     (pop),
    .out_item(out_item),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [rswm_pkg::SAMPLE_BITS-1:0] row_hist [HIST_DEPTH];
  int                               fill_cnt   = 0;
  logic [rswm_pkg::RAD_BITS-1:0]    cur_radius = rswm_pkg::RADIUS_RST;
  logic                             cur_dilate = rswm_pkg::MODE_RST;

  rswm_pkg::out_item_t expected_pixels[$];
  rswm_pkg::out_item_t head_pixel;
  int                  err_count    = 0;
  int                  cycle_cnt    = 0;
  int                  tx_idle_pct  = 0;
  int                  rx_stall_pct = 0;
  logic                rx_hold      = 1'b0;

  function automatic logic [rswm_pkg::SAMPLE_BITS-1:0] window_extreme(int span);
    logic [rswm_pkg::SAMPLE_BITS-1:0] acc;
    acc = row_hist[0];
    for (int k = 1; k <= span && k < fill_cnt && k < HIST_DEPTH; k++) begin
      if (cur_dilate ? (row_hist[k] > acc) : (row_hist[k] < acc)) acc = row_hist[k];
    end
    return acc;
  endfunction

  task automatic predict_window(input rswm_pkg::in_item_t px);
    int r;
    r = (int'(cur_radius) > rswm_pkg::MAX_RADIUS_DEF) ? rswm_pkg::MAX_RADIUS_DEF
                                                       : int'(cur_radius);
    for (int k = HIST_DEPTH - 1; k > 0; k--) row_hist[k] = row_hist[k-1];
    row_hist[0] = px.pixel_value;
    if (fill_cnt < FILL_SAT) fill_cnt++;
    if (!px.row_end) begin
      if (r < fill_cnt)
        expected_pixels.push_back('{filtered_value: window_extreme(2 * r), row_done: 1'b0});
    end else begin
      // flush: lag r down to 0, the last one closes the row
      for (int j = r; j >= 0; j--) begin
        if (j < fill_cnt)
          expected_pixels.push_back('{filtered_value: window_extreme(j + r),
                                      row_done: (j == 0)});
      end
      fill_cnt = 0;
    end
  endtask

  task automatic note_mismatch(input string what, input int want, input int got);
    err_count++;
    if (err_count <= MAX_REPORTS)
      $display("MISMATCH %s: expected %0h, got %0h", what, want, got);
  endtask

  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      if (expected_pixels.size() == 0) begin
        note_mismatch("word with nothing expected", 0, int'(out_item));
      end else begin
        head_pixel = expected_pixels.pop_front();
        if (out_item.filtered_value !== head_pixel.filtered_value)
          note_mismatch("filtered_value", head_pixel.filtered_value, out_item.filtered_value);
        if (out_item.row_done !== head_pixel.row_done)
          note_mismatch("row_done", head_pixel.row_done, out_item.row_done);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || rx_hold) begin
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_pixel(input logic [rswm_pkg::SAMPLE_BITS-1:0] v, input logic last);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push    <= 1'b1;
    in_item <= '{pixel_value: v, row_end: last};
    do @(posedge clk); while (full);
    predict_window('{pixel_value: v, row_end: last});
  endtask

  task automatic quiesce();
    push <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [rswm_pkg::PADDR_BITS-1:0] addr,
                           input logic [rswm_pkg::PDATA_BITS-1:0] data);
    logic [rswm_pkg::RAD_BITS-1:0] want;
    logic [rswm_pkg::RAD_BITS-1:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    // read back
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_RADIUS) begin
      cur_radius = data[rswm_pkg::RAD_BITS-1:0];
      want       = data[rswm_pkg::RAD_BITS-1:0];
      got        = prdata[rswm_pkg::RAD_BITS-1:0];
    end else begin
      cur_dilate = data[0];
      want       = {{(rswm_pkg::RAD_BITS-1){1'b0}}, data[0]};
      got        = {{(rswm_pkg::RAD_BITS-1){1'b0}}, prdata[0]};
    end
    if (got !== want) note_mismatch("register read", want, got);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_window(input int r, input logic d);
    quiesce();
    cfg_write(ADDR_RADIUS, r);
    cfg_write(ADDR_MODE, d);
  endtask

  function automatic logic [rswm_pkg::SAMPLE_BITS-1:0] rand_pixel();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2, 3:    return 16'h7FF0 + 16'($urandom_range(0, 31));
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic send_row(input int len);
    for (int i = 0; i < len; i++) send_pixel(rand_pixel(), i == len - 1);
  endtask

  function automatic int pick_row_len(input int r);
    case ($urandom_range(0, 9))
      0, 1:    return $urandom_range(1, 3);
      2:       return $urandom_range(1, 2 * r + 3);
      default: return $urandom_range(1, r + 4);
    endcase
  endfunction

  task automatic test_reset_defaults();
    tx_idle_pct  = 0;
    rx_stall_pct <= 0;
    send_pixel(16'h0000, 1'b0);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'h1234, 1'b1);
  endtask

  task automatic test_single_pixel_rows();
    set_window(3, 1'b1);
    send_pixel(16'hFFFF, 1'b1);
    set_window(3, 1'b0);
    send_pixel(16'h0000, 1'b1);
  endtask

  task automatic test_short_rows();
    set_window(31, 1'b1);
    send_pixel(16'h0001, 1'b0);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'h0000, 1'b0);
    send_pixel(16'h8000, 1'b1);
    set_window(31, 1'b0);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'h0001, 1'b0);
    send_pixel(16'hFFFE, 1'b1);
  endtask

  task automatic test_radius_change_mid_row();
    set_window(4, 1'b0);
    // too few pixels for any word yet
    send_pixel(16'h4000, 1'b0);
    send_pixel(16'h0010, 1'b0);
    send_pixel(16'hC000, 1'b0);
    quiesce();
    cfg_write(ADDR_RADIUS, 1);
    send_pixel(16'h0FFF, 1'b0);
    send_pixel(16'h0002, 1'b0);
    send_pixel(16'hA5A5, 1'b1);
  endtask

  task automatic test_long_row();
    tx_idle_pct  = 0;
    rx_stall_pct <= 0;
    set_window(31, 1'($urandom_range(0, 1)));
    send_row(130);
  endtask

  task automatic test_random_rows();
    int n;
    int r;
    logic d;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin tx_idle_pct = 0;  rx_stall_pct <= 0;  end
        1:       begin tx_idle_pct = 80; rx_stall_pct <= 0;  end
        2:       begin tx_idle_pct = 0;  rx_stall_pct <= 80; end
        default: begin tx_idle_pct = 29; rx_stall_pct <= 29; end
      endcase
      for (int s = 0; s < 2; s++) begin
        if (s == 0) begin
          r = (ph % 2 == 0) ? 0 : 31;
          d = 1'((ph / 2) % 2);
        end else begin
          r = $urandom_range(0, 31);
          d = 1'($urandom_range(0, 1));
        end
        set_window(r, d);
        n = 0;
        while (n < 4) begin
          r = pick_row_len(int'(cur_radius));
          send_row(r);
          n += r;
        end
      end
    end
  endtask

  task automatic test_backpressure();
    int n;
    int len;
    tx_idle_pct  = 0;
    rx_stall_pct <= 0;
    set_window(7, 1'b1);
    fork
      begin
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
      end
    join_none
    n = 0;
    while (n < 30) begin
      len = $urandom_range(4, 12);
      send_row(len);
      n += len;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_single_pixel_rows();
    test_short_rows();
    test_radius_change_mid_row();
    test_long_row();
    test_random_rows();
    test_backpressure();
    quiesce();
    if (err_count == 0 && expected_pixels.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
